/* rtl/byte_budget_lru_cache_macros.svh */
// Assertion macros used by the checker file of the byte budget LRU cache.
`ifndef BYTE_BUDGET_LRU_CACHE_MACROS_SVH
`define BYTE_BUDGET_LRU_CACHE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BBL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bbl check failed: same-cycle rule");

// Next-cycle implication, checked out of reset.
`define BBL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bbl check failed: next-cycle rule");

`endif

/* rtl/bbl_pkg.sv */
// Types, codes and defaults shared by the byte budget LRU cache modules.
package bbl_pkg;

	localparam int DEF_ENTRIES   = 64;
	localparam int DEF_KEY_WIDTH = 64;

	localparam logic [31:0] BUDGET_RESET = 32'd4194304;
	localparam logic [23:0] LIMIT_RESET  = 24'd1048576;

	localparam logic REG_BYTE_BUDGET = 1'b0;
	localparam logic REG_ENTRY_LIMIT = 1'b1;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_STORE  = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;
	localparam logic [1:0] REQ_CLEAR  = 2'd3;

	localparam logic [2:0] STS_HIT      = 3'd0;
	localparam logic [2:0] STS_MISS     = 3'd1;
	localparam logic [2:0] STS_INSERTED = 3'd2;
	localparam logic [2:0] STS_REPLACED = 3'd3;
	localparam logic [2:0] STS_REJECTED = 3'd4;
	localparam logic [2:0] STS_REMOVED  = 3'd5;
	localparam logic [2:0] STS_ABSENT   = 3'd6;
	localparam logic [2:0] STS_CLEARED  = 3'd7;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] lookup_key;
		logic [23:0] entry_bytes;
		logic [31:0] payload_ref;
	} cache_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] hit_payload_ref;
		logic [23:0] hit_bytes;
		logic [31:0] total_bytes;
		logic [6:0]  entry_count;
		logic [6:0]  evicted_count;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
	} cache_result_t;

	typedef enum logic [2:0] {
		SCAN_FIND,
		SCAN_PROMOTE,
		SCAN_INSERT,
		SCAN_DROP_SLOT,
		SCAN_DROP_OLDEST,
		SCAN_CLEAR
	} scan_op_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_INIT_CLR,
		ST_IDLE,
		ST_DISPATCH,
		ST_FIND,
		ST_PROMOTE,
		ST_INSERT,
		ST_DROP,
		ST_CLEAR,
		ST_TRIM_CHECK,
		ST_TRIM,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic       load;
		logic       scan_start;
		scan_op_t   scan_op;
		logic       set_status;
		logic [2:0] status;
		logic       hit_inc;
		logic       miss_inc;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       reject;
		logic       found;
		logic       over_budget;
		logic       scan_done;
	} dp_status_t;

endpackage

/* rtl/bbl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/bbl_ctrl.sv */
// Request sequencer: orders the slot scans that make up each cache request.
module bbl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output bbl_pkg::dp_cmd_t    cmd,
	input  bbl_pkg::dp_status_t sts
);

	import bbl_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.scan_op = SCAN_FIND;
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_FINISH);
		case (state_q)
			ST_INIT: begin
				cmd.scan_start = 1'b1;
				cmd.scan_op = SCAN_CLEAR;
				state_d = ST_INIT_CLR;
			end
			ST_INIT_CLR: begin
				if (sts.scan_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.req_type)
					REQ_CLEAR: begin
						cmd.scan_start = 1'b1;
						cmd.scan_op = SCAN_CLEAR;
						state_d = ST_CLEAR;
					end
					REQ_STORE: begin
						if (sts.reject) begin
							cmd.set_status = 1'b1;
							cmd.status = STS_REJECTED;
							state_d = ST_FINISH;
						end else begin
							cmd.scan_start = 1'b1;
							state_d = ST_FIND;
						end
					end
					default: begin
						cmd.scan_start = 1'b1;
						state_d = ST_FIND;
					end
				endcase
			end
			ST_FIND: begin
				if (sts.scan_done) begin
					case (sts.req_type)
						REQ_LOOKUP: begin
							if (sts.found) begin
								cmd.scan_start = 1'b1;
								cmd.scan_op = SCAN_PROMOTE;
								state_d = ST_PROMOTE;
							end else begin
								cmd.miss_inc = 1'b1;
								cmd.set_status = 1'b1;
								cmd.status = STS_MISS;
								state_d = ST_FINISH;
							end
						end
						REQ_STORE: begin
							cmd.scan_start = 1'b1;
							if (sts.found) begin
								cmd.scan_op = SCAN_PROMOTE;
								state_d = ST_PROMOTE;
							end else begin
								cmd.scan_op = SCAN_INSERT;
								state_d = ST_INSERT;
							end
						end
						default: begin
							if (sts.found) begin
								cmd.scan_start = 1'b1;
								cmd.scan_op = SCAN_DROP_SLOT;
								state_d = ST_DROP;
							end else begin
								cmd.set_status = 1'b1;
								cmd.status = STS_ABSENT;
								state_d = ST_FINISH;
							end
						end
					endcase
				end
			end
			ST_PROMOTE: begin
				if (sts.scan_done) begin
					cmd.set_status = 1'b1;
					if (sts.req_type == REQ_LOOKUP) begin
						cmd.hit_inc = 1'b1;
						cmd.status = STS_HIT;
						state_d = ST_FINISH;
					end else begin
						cmd.status = STS_REPLACED;
						state_d = ST_TRIM_CHECK;
					end
				end
			end
			ST_INSERT: begin
				if (sts.scan_done) begin
					cmd.set_status = 1'b1;
					cmd.status = STS_INSERTED;
					state_d = ST_TRIM_CHECK;
				end
			end
			ST_DROP: begin
				if (sts.scan_done) begin
					cmd.set_status = 1'b1;
					cmd.status = STS_REMOVED;
					state_d = ST_FINISH;
				end
			end
			ST_CLEAR: begin
				if (sts.scan_done) begin
					cmd.set_status = 1'b1;
					cmd.status = STS_CLEARED;
					state_d = ST_FINISH;
				end
			end
			ST_TRIM_CHECK: begin
				if (sts.over_budget) begin
					cmd.scan_start = 1'b1;
					cmd.scan_op = SCAN_DROP_OLDEST;
					state_d = ST_TRIM;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_TRIM: begin
				if (sts.scan_done) begin
					state_d = ST_TRIM_CHECK;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/bbl_dpath.sv */
// Slot store, scan engine, byte and entry accounting, and result registers.
module bbl_dpath #(
	parameter int ENTRIES   = bbl_pkg::DEF_ENTRIES,
	parameter int KEY_WIDTH = bbl_pkg::DEF_KEY_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bbl_pkg::cache_req_t   req,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [31:0]           cfg_wdata,
	input  bbl_pkg::dp_cmd_t      cmd,
	output bbl_pkg::dp_status_t   sts,
	output bbl_pkg::cache_result_t result
);

	import bbl_pkg::*;

	localparam int IW   = $clog2(ENTRIES);
	localparam int RW   = IW;
	localparam int CNW  = $clog2(ENTRIES + 1);
	localparam int TW   = 24 + CNW;
	localparam int CW   = (TW > 32) ? TW : 32;
	localparam int RECW = 1 + KEY_WIDTH + 24 + 32 + RW;
	localparam logic [IW-1:0]  LAST_IDX = IW'(ENTRIES - 1);
	localparam logic [CNW-1:0] FULL_CNT = CNW'(ENTRIES);

	logic [31:0] budget_q;
	logic [23:0] limit_q;

	logic [1:0]           req_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [23:0]          nbytes_q;
	logic [31:0]          pay_q;

	logic [TW-1:0]  total_q;
	logic [CNW-1:0] count_q;
	logic [CNW-1:0] evicted_q;
	logic [31:0]    hits_q, misses_q;
	logic [2:0]     status_q;

	logic           found_q, placed_q, dropped_q;
	logic [IW-1:0]  slot_q;
	logic [RW-1:0]  rank_q;
	logic [31:0]    hp_q;
	logic [23:0]    hb_q;

	scan_op_t       op_q;
	logic           run_q;
	logic [IW-1:0]  idx_q;
	logic           vld_s1;
	logic [IW-1:0]  idx_s1;

	logic            ram_we;
	logic [RECW-1:0] ram_wdata, ram_rdata;

	logic                 d_valid;
	logic [KEY_WIDTH-1:0] d_key;
	logic [23:0]          d_size;
	logic [31:0]          d_pay;
	logic [RW-1:0]        d_rank;
	logic [RW-1:0]        oldest_rank;
	logic                 full;
	logic                 at_slot, take_new, drop_this, key_match;

	bbl_ram #(.WIDTH(RECW), .DEPTH(ENTRIES)) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign d_rank  = ram_rdata[RW-1:0];
	assign d_pay   = ram_rdata[RW+31:RW];
	assign d_size  = ram_rdata[RW+55:RW+32];
	assign d_key   = ram_rdata[RW+56+KEY_WIDTH-1:RW+56];
	assign d_valid = ram_rdata[RECW-1];

	assign full        = (count_q == FULL_CNT);
	assign oldest_rank = RW'(count_q - CNW'(1));
	assign at_slot     = (idx_s1 == slot_q);
	assign key_match   = d_valid && (d_key == key_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = ram_rdata;
		take_new  = 1'b0;
		drop_this = 1'b0;
		case (op_q)
			SCAN_FIND: begin
				ram_we = 1'b0;
			end
			SCAN_PROMOTE: begin
				ram_we = vld_s1;
				if (at_slot) begin
					if (req_q == REQ_STORE) begin
						ram_wdata = {1'b1, d_key, nbytes_q, pay_q, RW'(0)};
					end else begin
						ram_wdata = {1'b1, d_key, d_size, d_pay, RW'(0)};
					end
				end else if (d_valid && (d_rank < rank_q)) begin
					ram_wdata[RW-1:0] = d_rank + RW'(1);
				end
			end
			SCAN_INSERT: begin
				ram_we = vld_s1;
				if (full) begin
					take_new = d_valid && (d_rank == oldest_rank) && !placed_q;
				end else begin
					take_new = !d_valid && !placed_q;
				end
				if (take_new) begin
					ram_wdata = {1'b1, key_q, nbytes_q, pay_q, RW'(0)};
				end else if (d_valid) begin
					ram_wdata[RW-1:0] = d_rank + RW'(1);
				end
			end
			SCAN_DROP_SLOT: begin
				ram_we = vld_s1;
				drop_this = at_slot;
				if (at_slot) begin
					ram_wdata[RECW-1] = 1'b0;
				end else if (d_valid && (d_rank > rank_q)) begin
					ram_wdata[RW-1:0] = d_rank - RW'(1);
				end
			end
			SCAN_DROP_OLDEST: begin
				drop_this = d_valid && (d_rank == oldest_rank) && !dropped_q;
				ram_we = vld_s1 && drop_this;
				ram_wdata[RECW-1] = 1'b0;
			end
			SCAN_CLEAR: begin
				ram_we = vld_s1;
				ram_wdata = '0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RESET;
			limit_q  <= LIMIT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_BYTE_BUDGET) begin
				budget_q <= cfg_wdata;
			end else begin
				limit_q <= cfg_wdata[23:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req.req_type;
			key_q    <= req.lookup_key[KEY_WIDTH-1:0];
			nbytes_q <= req.entry_bytes;
			pay_q    <= req.payload_ref;
		end
	end

	// Scan sequencing: one slot read per cycle, modified copy written back in the cycle after its read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			idx_q  <= '0;
			vld_s1 <= 1'b0;
			idx_s1 <= '0;
			op_q   <= SCAN_CLEAR;
		end else begin
			vld_s1 <= run_q;
			idx_s1 <= idx_q;
			if (cmd.scan_start) begin
				run_q <= 1'b1;
				idx_q <= '0;
				op_q  <= cmd.scan_op;
			end else if (run_q) begin
				if (idx_q == LAST_IDX) begin
					run_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			count_q   <= '0;
			evicted_q <= '0;
			hits_q    <= '0;
			misses_q  <= '0;
			status_q  <= STS_CLEARED;
			found_q   <= 1'b0;
			placed_q  <= 1'b0;
			dropped_q <= 1'b0;
			slot_q    <= '0;
			rank_q    <= '0;
			hp_q      <= '0;
			hb_q      <= '0;
		end else begin
			if (cmd.load) begin
				evicted_q <= '0;
			end
			if (cmd.hit_inc) begin
				hits_q <= hits_q + 32'd1;
			end
			if (cmd.miss_inc) begin
				misses_q <= misses_q + 32'd1;
			end
			if (cmd.set_status) begin
				status_q <= cmd.status;
			end
			if (cmd.scan_start) begin
				placed_q  <= 1'b0;
				dropped_q <= 1'b0;
				if (cmd.scan_op == SCAN_FIND) begin
					found_q <= 1'b0;
				end
				if (cmd.scan_op == SCAN_CLEAR) begin
					total_q <= '0;
					count_q <= '0;
				end
			end
			// A key search hands over to the next scan in the cycle of its last
			// slot, so that slot is still recorded here.
			if (vld_s1) begin
				case (op_q)
					SCAN_FIND: begin
						if (key_match && !found_q) begin
							found_q <= 1'b1;
							slot_q  <= idx_s1;
							rank_q  <= d_rank;
							hp_q    <= d_pay;
							hb_q    <= d_size;
						end
					end
					SCAN_PROMOTE: begin
						if (at_slot && (req_q == REQ_STORE)) begin
							total_q <= total_q - TW'(d_size) + TW'(nbytes_q);
						end
					end
					SCAN_INSERT: begin
						if (take_new) begin
							placed_q <= 1'b1;
							if (full) begin
								total_q <= total_q - TW'(d_size) + TW'(nbytes_q);
							end else begin
								total_q <= total_q + TW'(nbytes_q);
								count_q <= count_q + CNW'(1);
							end
						end
					end
					SCAN_DROP_SLOT: begin
						if (drop_this) begin
							total_q <= total_q - TW'(d_size);
							count_q <= count_q - CNW'(1);
						end
					end
					SCAN_DROP_OLDEST: begin
						if (drop_this) begin
							dropped_q <= 1'b1;
							total_q   <= total_q - TW'(d_size);
							count_q   <= count_q - CNW'(1);
							evicted_q <= evicted_q + CNW'(1);
						end
					end
					default: begin
						found_q <= found_q;
					end
				endcase
			end
		end
	end

	assign sts.req_type    = req_q;
	assign sts.reject      = (nbytes_q == 24'd0) || (nbytes_q > limit_q);
	assign sts.found       = found_q || ((op_q == SCAN_FIND) && vld_s1 && key_match);
	assign sts.over_budget = (CW'(total_q) > CW'(budget_q)) && (count_q != '0);
	assign sts.scan_done   = vld_s1 && (idx_s1 == LAST_IDX);

	always_comb begin
		result.status          = status_q;
		result.hit_payload_ref = (status_q == STS_HIT) ? hp_q : 32'd0;
		result.hit_bytes       = (status_q == STS_HIT) ? hb_q : 24'd0;
		result.total_bytes     = 32'(total_q);
		result.entry_count     = 7'(count_q);
		result.evicted_count   = 7'(evicted_q);
		result.hit_total       = hits_q;
		result.miss_total      = misses_q;
	end

endmodule

/* rtl/byte_budget_lru_cache.sv */
// Top level of the byte budget LRU cache: sequencer plus slot datapath.
//
// A request beat is taken when start is high and busy is low; exactly one
// result beat follows, shown on result for the single cycle in which done is
// high, and the receiver must take it then because nothing holds it. All
// work walks the slot memory one slot per clock through its single read port.
// A miss is a key search alone and a clear is a clearing scan alone; a hit,
// remove, replace or insert follows its key search with a promote, drop or
// insert scan, a rejected store scans nothing, and budget trimming runs a
// further scan for every entry that it evicts. After reset a clearing pass
// runs with busy high before the first request is taken; configuration writes
// are taken at any time, but are meant to be made while the cache is idle.
module byte_budget_lru_cache #(
	parameter int ENTRIES   = bbl_pkg::DEF_ENTRIES,
	parameter int KEY_WIDTH = bbl_pkg::DEF_KEY_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  bbl_pkg::cache_req_t    req,
	output logic                   done,
	output bbl_pkg::cache_result_t result,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [31:0]            cfg_wdata
);

	import bbl_pkg::*;

	// Commands run from the sequencer to the datapath; status flows back.
	dp_cmd_t    cmd;
	dp_status_t sts;

	bbl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	// The datapath holds the slot memory, the byte and entry totals and the
	// running hit and miss counters, and presents the result registers.
	bbl_dpath #(.ENTRIES(ENTRIES), .KEY_WIDTH(KEY_WIDTH)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

endmodule

/* rtl/bbl_checker.sv */
// Port-level checks of the byte budget LRU cache and their bind.
`include "byte_budget_lru_cache_macros.svh"

module bbl_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input bbl_pkg::cache_result_t result
);

	import bbl_pkg::*;

	`BBL_ASSERT_NOW(a_done_while_busy, done, busy)
	`BBL_ASSERT_NEXT(a_done_one_cycle, done, !done && !busy)
	`BBL_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
	`BBL_ASSERT_NOW(a_miss_has_no_payload, done && (result.status != STS_HIT),
		(result.hit_payload_ref == 32'd0) && (result.hit_bytes == 24'd0))

endmodule

bind byte_budget_lru_cache bbl_checker u_bbl_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

/* tb/sv/tb_byte_budget_lru_cache.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the byte budget LRU cache with its own cache predictor.
module tb_byte_budget_lru_cache;
	import bbl_pkg::*;

	localparam int SLOTS     = 64;
	localparam int MAX_CYCLE = 3000000;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	cache_req_t    req = '0;
	logic          done;
	cache_result_t result;
	logic          cfg_we = 1'b0;
	logic          cfg_index = 1'b0;
	logic [31:0]   cfg_wdata = '0;

	byte_budget_lru_cache DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Request beats waiting to be sent, and result beats still owed by the cache.
	cache_req_t    pending_reqs[$];
	cache_result_t owed_results[$];
	int            mismatches = 0;
	int            cycle = 0;

	// Shadow copy of the cache: table contents, recency ranks, totals and registers.
	logic [63:0]     shadow_key[SLOTS];
	logic [23:0]     shadow_size[SLOTS];
	logic [31:0]     shadow_payload[SLOTS];
	bit              shadow_valid[SLOTS];
	int              shadow_rank[SLOTS];
	longint unsigned shadow_total = 0;
	int              shadow_count = 0;
	logic [31:0]     shadow_hits = '0;
	logic [31:0]     shadow_misses = '0;
	logic [31:0]     budget_reg = BUDGET_RESET;
	logic [23:0]     limit_reg = LIMIT_RESET;

	initial begin
		for (int i = 0; i < SLOTS; i++)
			shadow_valid[i] = 1'b0;
	end

	function automatic int find_slot(logic [63:0] key);
		for (int i = 0; i < SLOTS; i++)
			if (shadow_valid[i] && shadow_key[i] == key)
				return i;
		return -1;
	endfunction

	// Moves a slot to rank zero; everything that was more recent ages by one.
	function automatic void promote_slot(int s);
		int r;
		r = shadow_rank[s];
		for (int i = 0; i < SLOTS; i++)
			if (shadow_valid[i] && shadow_rank[i] < r)
				shadow_rank[i]++;
		shadow_rank[s] = 0;
	endfunction

	function automatic void drop_slot(int s);
		int r;
		r = shadow_rank[s];
		shadow_total -= shadow_size[s];
		shadow_valid[s] = 1'b0;
		shadow_count--;
		for (int i = 0; i < SLOTS; i++)
			if (shadow_valid[i] && shadow_rank[i] > r)
				shadow_rank[i]--;
	endfunction

	function automatic int least_recent_slot();
		for (int i = 0; i < SLOTS; i++)
			if (shadow_valid[i] && shadow_rank[i] + 1 == shadow_count)
				return i;
		return -1;
	endfunction

	// Applies one request to the shadow cache and returns the result it must produce.
	function automatic cache_result_t apply_request(cache_req_t rq);
		cache_result_t res;
		int s;
		int trimmed;
		res = '0;
		trimmed = 0;
		case (rq.req_type)
			REQ_LOOKUP: begin
				s = find_slot(rq.lookup_key);
				if (s < 0) begin
					shadow_misses++;
					res.status = STS_MISS;
				end else begin
					shadow_hits++;
					promote_slot(s);
					res.status = STS_HIT;
					res.hit_payload_ref = shadow_payload[s];
					res.hit_bytes = shadow_size[s];
				end
			end
			REQ_STORE: begin
				if (rq.entry_bytes == 0 || rq.entry_bytes > limit_reg) begin
					res.status = STS_REJECTED;
				end else begin
					s = find_slot(rq.lookup_key);
					if (s >= 0) begin
						shadow_total = shadow_total - shadow_size[s] + rq.entry_bytes;
						shadow_size[s] = rq.entry_bytes;
						shadow_payload[s] = rq.payload_ref;
						promote_slot(s);
						res.status = STS_REPLACED;
					end else begin
						// A full table gives up its least recent entry first,
						// which does not count as a trim eviction.
						if (shadow_count >= SLOTS) begin
							s = least_recent_slot();
							if (s >= 0)
								drop_slot(s);
						end
						s = -1;
						for (int i = 0; i < SLOTS && s < 0; i++)
							if (!shadow_valid[i])
								s = i;
						if (s >= 0) begin
							for (int i = 0; i < SLOTS; i++)
								if (shadow_valid[i])
									shadow_rank[i]++;
							shadow_valid[s] = 1'b1;
							shadow_key[s] = rq.lookup_key;
							shadow_size[s] = rq.entry_bytes;
							shadow_payload[s] = rq.payload_ref;
							shadow_rank[s] = 0;
							shadow_count++;
							shadow_total += rq.entry_bytes;
						end
						res.status = STS_INSERTED;
					end
					// Trimming may throw out the entry just written.
					while (shadow_total > budget_reg && shadow_count > 0) begin
						s = least_recent_slot();
						if (s < 0)
							break;
						drop_slot(s);
						trimmed++;
					end
				end
			end
			REQ_REMOVE: begin
				s = find_slot(rq.lookup_key);
				if (s >= 0) begin
					drop_slot(s);
					res.status = STS_REMOVED;
				end else begin
					res.status = STS_ABSENT;
				end
			end
			default: begin
				for (int i = 0; i < SLOTS; i++)
					shadow_valid[i] = 1'b0;
				shadow_count = 0;
				shadow_total = 0;
				res.status = STS_CLEARED;
			end
		endcase
		res.total_bytes = shadow_total[31:0];
		res.entry_count = shadow_count[6:0];
		res.evicted_count = trimmed[6:0];
		res.hit_total = shadow_hits;
		res.miss_total = shadow_misses;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle, what, got, want);
	endtask

	// Sender: bursts of beats separated by random gaps. The request held on req
	// stays put while start and busy are both high, so a beat is not changed before it is taken.
	int burst_left = 4;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				owed_results.push_back(apply_request(pending_reqs.pop_front()));
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					start <= 1'b1;
					req <= pending_reqs[0];
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						// Some bursts run back to back with no gap at all.
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Receiver: the cache cannot be held off, so every done beat is checked at once.
	always @(posedge clk) begin
		cache_result_t want;
		cycle <= cycle + 1;
		if (arst_n && done) begin
			if (owed_results.size() == 0) begin
				report_mismatch("unexpected result beat, status", 64'(result.status),
					64'd0);
			end else begin
				want = owed_results.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", 64'(result.status), 64'(want.status));
				if (result.hit_payload_ref !== want.hit_payload_ref)
					report_mismatch("hit_payload_ref", 64'(result.hit_payload_ref),
						64'(want.hit_payload_ref));
				if (result.hit_bytes !== want.hit_bytes)
					report_mismatch("hit_bytes", 64'(result.hit_bytes),
						64'(want.hit_bytes));
				if (result.total_bytes !== want.total_bytes)
					report_mismatch("total_bytes", 64'(result.total_bytes),
						64'(want.total_bytes));
				if (result.entry_count !== want.entry_count)
					report_mismatch("entry_count", 64'(result.entry_count),
						64'(want.entry_count));
				if (result.evicted_count !== want.evicted_count)
					report_mismatch("evicted_count", 64'(result.evicted_count),
						64'(want.evicted_count));
				if (result.hit_total !== want.hit_total)
					report_mismatch("hit_total", 64'(result.hit_total),
						64'(want.hit_total));
				if (result.miss_total !== want.miss_total)
					report_mismatch("miss_total", 64'(result.miss_total),
						64'(want.miss_total));
			end
		end
		if (cycle > MAX_CYCLE) begin
			$display("timeout after %0d cycles", cycle);
			$display("[byte_budget_lru_cache] ERROR");
			$finish;
		end
	end

	function automatic void queue_request(logic [1:0] kind, logic [63:0] key,
		logic [23:0] nbytes, logic [31:0] handle);
		cache_req_t rq;
		rq.req_type = kind;
		rq.lookup_key = key;
		rq.entry_bytes = nbytes;
		rq.payload_ref = handle;
		pending_reqs.push_back(rq);
	endfunction

	// Waits until every request was sent and every result came back, then lets
	// the cache finish its last sequence before the registers are touched.
	task automatic wait_drained();
		wait (pending_reqs.size() == 0 && !start && owed_results.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(logic idx, logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BYTE_BUDGET)
			budget_reg = value;
		else
			limit_reg = value[23:0];
	endtask

	// One random phase: keys come mostly from a pool of pool_size random keys,
	// sizes from zero to size_span (the whole field when size_span is all ones).
	task automatic random_phase(int count, int pool_size, logic [23:0] size_span);
		logic [63:0] pool[$];
		logic [63:0] key;
		logic [23:0] nbytes;
		int pick;
		for (int i = 0; i < pool_size; i++)
			pool.push_back({$urandom, $urandom});
		for (int n = 0; n < count; n++) begin
			key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
				: pool[$urandom_range(0, pool_size - 1)];
			nbytes = (size_span == '1) ? 24'($urandom)
				: 24'($urandom_range(0, size_span));
			pick = $urandom_range(0, 99);
			if (pick < 45)
				queue_request(REQ_STORE, key, nbytes, $urandom);
			else if (pick < 80)
				queue_request(REQ_LOOKUP, key, 24'($urandom), $urandom);
			else if (pick < 97)
				queue_request(REQ_REMOVE, key, 24'($urandom), $urandom);
			else
				queue_request(REQ_CLEAR, key, 24'($urandom), $urandom);
		end
		wait_drained();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening at reset settings: a miss, stores at both size
		// extremes and all-zero and all-one keys and handles, rejects of empty
		// and oversize stores (one on a present key), hits, a replace, a remove
		// of a present and an absent key, trimming at the budget, and a clear.
		queue_request(REQ_LOOKUP, 64'd0, 24'd0, 32'd0);
		queue_request(REQ_STORE, 64'd0, 24'd1, 32'd0);
		queue_request(REQ_STORE, '1, LIMIT_RESET, '1);
		queue_request(REQ_STORE, 64'd5, 24'd0, 32'd7);
		queue_request(REQ_STORE, 64'd5, LIMIT_RESET + 24'd1, 32'd7);
		queue_request(REQ_STORE, '1, '1, 32'd9);
		queue_request(REQ_LOOKUP, '1, 24'd0, 32'd0);
		queue_request(REQ_LOOKUP, 64'd0, 24'd0, 32'd0);
		queue_request(REQ_STORE, 64'd0, 24'd100, 32'h1234_5678);
		queue_request(REQ_REMOVE, 64'd5, 24'd0, 32'd0);
		queue_request(REQ_REMOVE, 64'd0, 24'd0, 32'd0);
		queue_request(REQ_LOOKUP, 64'd0, 24'd0, 32'd0);
		for (int i = 0; i < 5; i++)
			queue_request(REQ_STORE, 64'h100 + i, LIMIT_RESET, 32'hA000 + i);
		queue_request(REQ_LOOKUP, 64'h100, 24'd0, 32'd0);
		queue_request(REQ_CLEAR, 64'd0, 24'd0, 32'd0);
		queue_request(REQ_LOOKUP, '1, 24'd0, 32'd0);
		wait_drained();

		// Small sizes against the reset budget: the table fills and overflows.
		random_phase(400, 72, 24'd2000);
		// A lower budget leaves the old total standing until the next store.
		write_register(REG_BYTE_BUDGET, 32'd5000);
		write_register(REG_ENTRY_LIMIT, 32'd3000);
		random_phase(400, 72, 24'd3200);
		// A zero budget: every accepted store trims its own entry away.
		write_register(REG_BYTE_BUDGET, 32'd0);
		write_register(REG_ENTRY_LIMIT, 32'd16);
		random_phase(150, 40, 24'd20);
		// Both registers at their largest: sizes cover the whole field.
		write_register(REG_BYTE_BUDGET, 32'hFFFF_FFFF);
		write_register(REG_ENTRY_LIMIT, 32'h00FF_FFFF);
		random_phase(300, 72, '1);
		// A zero entry limit rejects every store.
		write_register(REG_ENTRY_LIMIT, 32'd0);
		write_register(REG_BYTE_BUDGET, 32'd1);
		random_phase(100, 30, 24'd8);
		// A small key pool for many hits, replaces and removes.
		write_register(REG_BYTE_BUDGET, 32'd40000);
		write_register(REG_ENTRY_LIMIT, 32'd1000);
		random_phase(500, 20, 24'd1100);

		repeat (300) @(posedge clk);
		if (mismatches == 0 && owed_results.size() == 0) begin
			$display("[byte_budget_lru_cache] OK");
		end else begin
			$display("[byte_budget_lru_cache] ERROR");
		end
		$finish;
	end

endmodule

/* byte_budget_lru_cache.f */
+incdir+rtl
rtl/bbl_pkg.sv
rtl/bbl_ram.sv
rtl/bbl_ctrl.sv
rtl/bbl_dpath.sv
rtl/byte_budget_lru_cache.sv
rtl/bbl_checker.sv
tb/sv/tb_byte_budget_lru_cache.sv
